[rtl/direct_form_fir_iir_filter_macros.svh]
// assertion macros shared by the filter rtl
`ifndef DIRECT_FORM_FIR_IIR_FILTER_MACROS_SVH
`define DIRECT_FORM_FIR_IIR_FILTER_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define DFIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define DFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dfir_pkg.sv]
// shared types, constants and microprogram table for the direct-form filter
package dfir_pkg;

  localparam int unsigned MAX_ORDER  = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 20;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned COEF_IDX_W = 3;
  localparam int unsigned DATA_IDX_W = 2;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_TAP_B0   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_A1   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IIR_MODE = 3'd7;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // one microprogram word
  typedef struct packed {
    logic                  mul_en;
    logic                  sub;
    logic                  src_y;
    logic [COEF_IDX_W-1:0] coef_idx;
    logic [DATA_IDX_W-1:0] data_idx;
    logic                  skip_fir;
    logic [STEP_W-1:0]     jump_to;
    logic                  done;
  } uword_t;

  // datapath control from the sequencer
  typedef struct packed {
    logic                  clr;
    logic                  mul_en;
    logic                  sub;
    logic                  src_y;
    logic [COEF_IDX_W-1:0] coef_idx;
    logic [DATA_IDX_W-1:0] data_idx;
    logic                  res_load;
    logic                  busy;
  } dp_ctl_t;

  // microprogram rom
  // steps 0..order-1: feedforward taps, oldest input first
  // steps order..2*order-2: feedback taps, skipped in fir mode
  // step 2*order-1: drain the product register, step 2*order: emit
  function automatic uword_t ucode(input int unsigned order, input logic [STEP_W-1:0] step);
    uword_t      w;
    int unsigned s;
    int unsigned k;
    w = '0;
    s = int'(step);
    k = 0;
    if (s < order) begin
      w.mul_en   = 1'b1;
      w.coef_idx = REG_TAP_B0 + COEF_IDX_W'(s);
      w.data_idx = DATA_IDX_W'(order - 1 - s);
      if (s == order - 1) begin
        w.skip_fir = 1'b1;
        w.jump_to  = STEP_W'(2 * order - 1);
      end
    end else if (s < 2 * order - 1) begin
      k          = s - order;
      w.mul_en   = 1'b1;
      w.sub      = 1'b1;
      w.src_y    = 1'b1;
      w.coef_idx = REG_TAP_A1 + COEF_IDX_W'(k);
      w.data_idx = DATA_IDX_W'(k);
    end else if (s == 2 * order) begin
      w.done = 1'b1;
    end
    return w;
  endfunction

endpackage

[rtl/dfir_seq.sv]
// microcoded sequencer: step counter, program rom and fir skip jump
module dfir_seq #(
  parameter int unsigned ORDER = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              iir_mode,
  input  logic              out_free,
  output logic              in_ready,
  output dfir_pkg::dp_ctl_t ctl
);

  dfir_pkg::seq_state_t              state_r, state_nxt;
  logic [dfir_pkg::STEP_W-1:0]       step_r, step_nxt;
  dfir_pkg::uword_t                  word;

  // program rom lookup
  assign word = dfir_pkg::ucode(ORDER, step_r);

  // next state and step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      dfir_pkg::SEQ_IDLE: begin
        step_nxt = '0;
        if (start) begin
          state_nxt = dfir_pkg::SEQ_RUN;
        end
      end
      dfir_pkg::SEQ_RUN: begin
        if (word.done) begin
          if (out_free) begin
            state_nxt = dfir_pkg::SEQ_IDLE;
            step_nxt  = '0;
          end
        end else if (word.skip_fir && !iir_mode) begin
          step_nxt = word.jump_to;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = dfir_pkg::SEQ_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // control outputs
  always_comb begin
    ctl          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      dfir_pkg::SEQ_IDLE: begin
        in_ready = 1'b1;
        ctl.clr  = start;
      end
      dfir_pkg::SEQ_RUN: begin
        ctl.busy     = 1'b1;
        ctl.mul_en   = word.mul_en;
        ctl.sub      = word.sub;
        ctl.src_y    = word.src_y;
        ctl.coef_idx = word.coef_idx;
        ctl.data_idx = word.data_idx;
        ctl.res_load = word.done && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfir_pkg::SEQ_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[rtl/dfir_mac.sv]
// shared multiply-accumulate with truncation toward zero and saturation
module dfir_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dfir_pkg::dp_ctl_t                     ctl,
  input  logic signed [dfir_pkg::COEF_W-1:0]    coef,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0]  data,
  output logic signed [dfir_pkg::SAMPLE_W-1:0]  result
);

  localparam int unsigned PROD_W = dfir_pkg::COEF_W + dfir_pkg::SAMPLE_W;
  localparam int unsigned ACC_W  = PROD_W + 4;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned Q_W    = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_r;
  logic                     acc_en_r;
  logic                     sub_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  biased;
  logic signed [Q_W-1:0]    q_wide;
  logic                     ovf;

  // multiplier stage
  assign prod_w = coef * data;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      sub_r    <= 1'b0;
    end else begin
      acc_en_r <= ctl.mul_en;
      sub_r    <= ctl.sub;
    end
  end

  // accumulate stage
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  // drop fraction toward zero: add all-ones fraction when negative, then shift
  assign bias   = acc_r[ACC_W-1] ? {{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{1'b1}}} : '0;
  assign biased = acc_r + bias;
  assign q_wide = biased[ACC_W-1:FRAC_W];

  // saturate when the upper bits are not a sign extension
  assign ovf = (q_wide[Q_W-1:dfir_pkg::SAMPLE_W-1] != '0) &&
               (q_wide[Q_W-1:dfir_pkg::SAMPLE_W-1] != '1);

  always_comb begin
    if (ovf) begin
      result = q_wide[Q_W-1] ? {1'b1, {(dfir_pkg::SAMPLE_W - 1){1'b0}}}
                             : {1'b0, {(dfir_pkg::SAMPLE_W - 1){1'b1}}};
    end else begin
      result = q_wide[dfir_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

[rtl/direct_form_fir_iir_filter.sv]
// direct-form fir / iir filter, one shared mac driven by a microprogram
// the single multiplier-accumulator steps through one tap per cycle, skipping the feedback taps in fir mode,
//   then drains and emits; a new sample is accepted only while the program is idle
// samples that only fill the history start no program and give no beat
// sync active-low reset clears coefficients, mode, both histories and the fill count
`include "direct_form_fir_iir_filter_macros.svh"

module direct_form_fir_iir_filter #(
  parameter int unsigned ORDER = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [15:0]                          in_tdata,   // [15:0] sample_in
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,  // [15:0] sample_out
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [dfir_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  logic [dfir_pkg::COEF_W-1:0]          cfg_wdata
);

  localparam int unsigned HIST_IDX_W = $clog2(ORDER);

  logic signed [dfir_pkg::COEF_W-1:0]   coef_r [dfir_pkg::NUM_REGS-1];
  logic                                 iir_mode_r;
  logic signed [dfir_pkg::SAMPLE_W-1:0] x_sr_r [ORDER];
  logic signed [dfir_pkg::SAMPLE_W-1:0] y_sr_r [ORDER];
  logic [HIST_IDX_W-1:0]                fill_r;
  logic                                 full;
  logic                                 in_fire;
  logic                                 start;
  logic                                 out_free;
  logic                                 out_valid_r;
  logic [dfir_pkg::SAMPLE_W-1:0]        out_data_r;
  logic signed [dfir_pkg::COEF_W-1:0]   coef_sel;
  logic signed [dfir_pkg::SAMPLE_W-1:0] data_sel;
  logic signed [dfir_pkg::SAMPLE_W-1:0] mac_result;
  logic [HIST_IDX_W-1:0]                hist_idx;
  dfir_pkg::dp_ctl_t                    ctl;

  assign in_fire  = in_tvalid && in_tready;
  assign full     = (fill_r == HIST_IDX_W'(ORDER - 1));
  assign start    = in_fire && full;
  assign out_free = !out_valid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(dfir_pkg::NUM_REGS) - 1; i++) begin
        coef_r[i] <= '0;
      end
      iir_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == dfir_pkg::REG_IIR_MODE) begin
        iir_mode_r <= cfg_wdata[0];
      end else begin
        coef_r[cfg_addr] <= cfg_wdata;
      end
    end
  end

  // fill count, holds once the history is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire && !full) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // input history, newest at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(ORDER); i++) begin
        x_sr_r[i] <= '0;
      end
    end else if (in_fire) begin
      x_sr_r[0] <= in_tdata;
      for (int i = 1; i < int'(ORDER); i++) begin
        x_sr_r[i] <= x_sr_r[i-1];
      end
    end
  end

  // output history, most recent result at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(ORDER); i++) begin
        y_sr_r[i] <= '0;
      end
    end else if (ctl.res_load) begin
      y_sr_r[0] <= mac_result;
      for (int i = 1; i < int'(ORDER); i++) begin
        y_sr_r[i] <= y_sr_r[i-1];
      end
    end
  end

  // operand selection
  assign hist_idx = ctl.data_idx[HIST_IDX_W-1:0];
  assign coef_sel = coef_r[ctl.coef_idx];
  assign data_sel = ctl.src_y ? y_sr_r[hist_idx] : x_sr_r[hist_idx];

  dfir_seq #(
    .ORDER (ORDER)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .iir_mode (iir_mode_r),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  dfir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .coef   (coef_sel),
    .data   (data_sel),
    .result (mac_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_data_r <= mac_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `DFIR_ASSERT_IMPL(a_load_free, ctl.res_load, !out_tvalid || out_tready, "result overwrote a waiting beat")
  `DFIR_ASSERT_NEXT(a_start_busy, start, ctl.busy && !in_tready, "full history did not start the program")
  `DFIR_ASSERT_NEXT(a_load_valid, ctl.res_load, out_tvalid, "loaded result not presented")
  `DFIR_ASSERT_IMPL(a_busy_full, ctl.busy, full, "program running before history filled")

endmodule
